[hw/rtl/ptfa_pkg.sv]
package ptfa_pkg;

  // default sizes
  localparam int unsigned FRAME_COUNT_DEF = 64;
  localparam int unsigned PAGE_BITS_DEF   = 8;
  localparam int unsigned PAGE_COUNT_DEF  = 256;

  // the frame bitmap is kept as rows of busy bits
  localparam int unsigned ROW_W = 32;
  localparam int unsigned BIT_W = $clog2(ROW_W);

  // page table entry: frame, present, read, write, execute
  localparam int unsigned ENT_W         = 10;
  localparam int unsigned ENT_FRAME_W   = 6;
  localparam int unsigned ENT_PRESENT   = 6;
  localparam logic [3:0]  ENT_MAP_FLAGS = 4'b1111;

  // operation codes
  localparam logic [2:0] OP_ALLOC      = 3'd0;
  localparam logic [2:0] OP_FREE_FRAME = 3'd1;
  localparam logic [2:0] OP_MAP        = 3'd2;
  localparam logic [2:0] OP_FREE_TABLE = 3'd3;
  localparam logic [2:0] OP_TRANSLATE  = 3'd4;
  localparam logic [2:0] OP_COUNT      = 3'd5;

  // result status codes
  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_NO_FRAME    = 2'd1;
  localparam logic [1:0] ST_NOT_PRESENT = 2'd2;

  // one result word
  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  frame_id;
    logic [13:0] phys_addr;
    logic [6:0]  free_frames;
  } res_t;

  // lowest free bit of one bitmap row
  typedef struct packed {
    logic             found;
    logic [BIT_W-1:0] idx;
  } pick_t;

endpackage

[hw/rtl/page_table_frame_allocator.sv]
// Map, free frame, translate and count: taken in S_IDLE, result registered from S_EXEC,
// or from S_HOLD while the output is stalled; the next word is taken back in S_IDLE.
// Allocate scans the bitmap one 32-frame row per cycle up to a free frame or the last row.
// Free table walks the table one entry per cycle, pausing in S_FT_BUSY for a bitmap
// read-modify-write after each present entry whose frame lies below FRAME_COUNT.
// Reset: a clearing pass writes zeros to both memories, in_stall_o high.
module page_table_frame_allocator #(
  parameter int unsigned FRAME_COUNT = ptfa_pkg::FRAME_COUNT_DEF,
  parameter int unsigned PAGE_BITS   = ptfa_pkg::PAGE_BITS_DEF,
  parameter int unsigned PAGE_COUNT  = ptfa_pkg::PAGE_COUNT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  opcode_i,
  input  logic [15:0] vaddr_i,
  input  logic [7:0]  page_i,
  input  logic [5:0]  frame_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [5:0]  frame_id_o,
  output logic [13:0] phys_addr_o,
  output logic [6:0]  free_frames_o
);

  localparam int unsigned ROWS   = (FRAME_COUNT + ptfa_pkg::ROW_W - 1) / ptfa_pkg::ROW_W;
  localparam int unsigned ROW_AW = ROWS > 1 ? $clog2(ROWS) : 1;
  localparam int unsigned PT_AW  = PAGE_COUNT > 1 ? $clog2(PAGE_COUNT) : 1;
  localparam int unsigned CLR_N  = PAGE_COUNT > ROWS ? PAGE_COUNT : ROWS;
  localparam int unsigned CLR_W  = CLR_N > 1 ? $clog2(CLR_N) : 1;
  localparam int unsigned CNT_W  = $clog2(FRAME_COUNT + 1);
  localparam logic [15:0] OFF_MASK = 16'((1 << PAGE_BITS) - 1);

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_EXEC,
    S_ALLOC,
    S_FT_CHK,
    S_FT_BUSY,
    S_HOLD
  } state_e;

  state_e                        state_q, state_d;
  logic [CLR_W-1:0]              clr_q, clr_d;
  logic [PT_AW-1:0]              ptr_q, ptr_d;
  logic [ROW_AW-1:0]             row_q, row_d;
  logic [CNT_W-1:0]              cnt_q, cnt_d;
  logic [2:0]                    opcode_q, opcode_d;
  logic [15:0]                   vaddr_q, vaddr_d;
  logic [7:0]                    page_q, page_d;
  logic [5:0]                    frame_q, frame_d;
  logic [5:0]                    ftf_q, ftf_d;
  logic                          out_valid_q, out_valid_d;
  ptfa_pkg::res_t                out_q, out_d;
  ptfa_pkg::res_t                hold_q, hold_d;
  ptfa_pkg::res_t                res;

  logic                          pt_we;
  logic [PT_AW-1:0]              pt_waddr, pt_raddr;
  logic [ptfa_pkg::ENT_W-1:0]    pt_wdata, pt_rdata;
  logic                          bm_we;
  logic [ROW_AW-1:0]             bm_waddr, bm_raddr;
  logic [ptfa_pkg::ROW_W-1:0]    bm_wdata, bm_rdata;
  ptfa_pkg::pick_t               pick;

  logic                          accept;
  logic                          slot_free;
  logic                          fin;
  logic [15:0]                   vpage;
  logic [21:0]                   pa_full;
  logic [10:0]                   free_n;

  function automatic logic [ROW_AW-1:0] frame_row(input logic [5:0] f);
    return ROW_AW'(f >> ptfa_pkg::BIT_W);
  endfunction

  function automatic logic [ptfa_pkg::ROW_W-1:0] frame_bit(input logic [5:0] f);
    return ptfa_pkg::ROW_W'(1) << f[ptfa_pkg::BIT_W-1:0];
  endfunction

  // page table memory
  ptfa_ram #(
    .WIDTH (ptfa_pkg::ENT_W),
    .DEPTH (PAGE_COUNT)
  ) u_pt_ram (
    .clk_i   (clk_i),
    .we_i    (pt_we),
    .waddr_i (pt_waddr),
    .wdata_i (pt_wdata),
    .raddr_i (pt_raddr),
    .rdata_o (pt_rdata)
  );

  // frame busy bitmap memory
  ptfa_ram #(
    .WIDTH (ptfa_pkg::ROW_W),
    .DEPTH (ROWS)
  ) u_bm_ram (
    .clk_i   (clk_i),
    .we_i    (bm_we),
    .waddr_i (bm_waddr),
    .wdata_i (bm_wdata),
    .raddr_i (bm_raddr),
    .rdata_o (bm_rdata)
  );

  // lowest free frame in the row being scanned
  ptfa_find_free #(
    .FRAME_COUNT (FRAME_COUNT),
    .ROW_AW      (ROW_AW)
  ) u_find_free (
    .row_i  (row_q),
    .busy_i (bm_rdata),
    .pick_o (pick)
  );

  assign accept    = in_valid_i && (state_q == S_IDLE);
  assign slot_free = !out_valid_q || !out_stall_i;
  assign vpage     = vaddr_i >> PAGE_BITS;
  assign pa_full   = (22'(pt_rdata[ptfa_pkg::ENT_FRAME_W-1:0]) << PAGE_BITS) |
                     22'(vaddr_q & OFF_MASK);
  assign free_n    = 11'(FRAME_COUNT) - 11'(cnt_d);

  // sequencer: memory reads, read-modify-write and result assembly
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    ptr_d       = ptr_q;
    row_d       = row_q;
    cnt_d       = cnt_q;
    opcode_d    = opcode_q;
    vaddr_d     = vaddr_q;
    page_d      = page_q;
    frame_d     = frame_q;
    ftf_d       = ftf_q;
    hold_d      = hold_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    pt_we       = 1'b0;
    pt_waddr    = '0;
    pt_wdata    = '0;
    pt_raddr    = '0;
    bm_we       = 1'b0;
    bm_waddr    = '0;
    bm_wdata    = '0;
    bm_raddr    = '0;
    fin         = 1'b0;
    res         = '0;
    res.status  = ptfa_pkg::ST_OK;

    unique case (state_q)
      // zero both memories after reset
      S_CLR: begin
        pt_we    = 32'(clr_q) < PAGE_COUNT;
        pt_waddr = PT_AW'(clr_q);
        bm_we    = 32'(clr_q) < ROWS;
        bm_waddr = ROW_AW'(clr_q);
        if (clr_q == CLR_W'(CLR_N - 1)) begin
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end

      // take a word and start its reads
      S_IDLE: begin
        pt_raddr = (opcode_i == ptfa_pkg::OP_FREE_TABLE) ? '0 : PT_AW'(vpage);
        bm_raddr = (opcode_i == ptfa_pkg::OP_ALLOC) ? '0 : frame_row(frame_i);
        if (accept) begin
          opcode_d = opcode_i;
          vaddr_d  = vaddr_i;
          page_d   = page_i;
          frame_d  = frame_i;
          row_d    = '0;
          ptr_d    = '0;
          if (opcode_i == ptfa_pkg::OP_ALLOC) begin
            state_d = S_ALLOC;
          end else if (opcode_i == ptfa_pkg::OP_FREE_TABLE) begin
            state_d = S_FT_CHK;
          end else begin
            state_d = S_EXEC;
          end
        end
      end

      // single-access operations
      S_EXEC: begin
        fin = 1'b1;
        unique case (opcode_q)
          ptfa_pkg::OP_FREE_FRAME: begin
            if (32'(frame_q) < FRAME_COUNT) begin
              bm_we    = 1'b1;
              bm_waddr = frame_row(frame_q);
              bm_wdata = bm_rdata & ~frame_bit(frame_q);
              if ((bm_rdata & frame_bit(frame_q)) != '0) begin
                cnt_d = cnt_q - 1'b1;
              end
            end
          end
          ptfa_pkg::OP_MAP: begin
            if (32'(page_q) < PAGE_COUNT) begin
              pt_we    = 1'b1;
              pt_waddr = PT_AW'(page_q);
              pt_wdata = {ptfa_pkg::ENT_MAP_FLAGS, frame_q};
            end
          end
          ptfa_pkg::OP_TRANSLATE: begin
            if ((32'(vaddr_q >> PAGE_BITS) >= PAGE_COUNT) ||
                !pt_rdata[ptfa_pkg::ENT_PRESENT]) begin
              res.status = ptfa_pkg::ST_NOT_PRESENT;
            end else begin
              res.phys_addr = pa_full[13:0];
            end
          end
          default: begin
          end
        endcase
      end

      // scan bitmap rows for the lowest free frame
      S_ALLOC: begin
        if (pick.found) begin
          bm_we          = 1'b1;
          bm_waddr       = row_q;
          bm_wdata       = bm_rdata | (ptfa_pkg::ROW_W'(1) << pick.idx);
          cnt_d          = cnt_q + 1'b1;
          res.frame_id   = 6'({row_q, pick.idx});
          fin            = 1'b1;
        end else if (row_q == ROW_AW'(ROWS - 1)) begin
          res.status = ptfa_pkg::ST_NO_FRAME;
          fin        = 1'b1;
        end else begin
          row_d    = row_q + 1'b1;
          bm_raddr = row_q + 1'b1;
        end
      end

      // table walk: clear present entries, release their frames
      S_FT_CHK: begin
        ftf_d = pt_rdata[ptfa_pkg::ENT_FRAME_W-1:0];
        if (pt_rdata[ptfa_pkg::ENT_PRESENT]) begin
          pt_we    = 1'b1;
          pt_waddr = ptr_q;
        end
        if (pt_rdata[ptfa_pkg::ENT_PRESENT] &&
            (32'(pt_rdata[ptfa_pkg::ENT_FRAME_W-1:0]) < FRAME_COUNT)) begin
          bm_raddr = frame_row(pt_rdata[ptfa_pkg::ENT_FRAME_W-1:0]);
          state_d  = S_FT_BUSY;
        end else if (ptr_q == PT_AW'(PAGE_COUNT - 1)) begin
          fin = 1'b1;
        end else begin
          ptr_d    = ptr_q + 1'b1;
          pt_raddr = ptr_q + 1'b1;
        end
      end

      S_FT_BUSY: begin
        bm_we    = 1'b1;
        bm_waddr = frame_row(ftf_q);
        bm_wdata = bm_rdata & ~frame_bit(ftf_q);
        if ((bm_rdata & frame_bit(ftf_q)) != '0) begin
          cnt_d = cnt_q - 1'b1;
        end
        if (ptr_q == PT_AW'(PAGE_COUNT - 1)) begin
          fin = 1'b1;
        end else begin
          ptr_d    = ptr_q + 1'b1;
          pt_raddr = ptr_q + 1'b1;
          state_d  = S_FT_CHK;
        end
      end

      // result waits for the output register
      S_HOLD: begin
        if (slot_free) begin
          out_d       = hold_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // finished word goes to the output register or the hold register
    res.free_frames = (free_n > 11'd127) ? 7'd127 : free_n[6:0];
    if (fin) begin
      if (slot_free) begin
        out_d       = res;
        out_valid_d = 1'b1;
        state_d     = S_IDLE;
      end else begin
        hold_d  = res;
        state_d = S_HOLD;
      end
    end
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      ptr_q       <= '0;
      row_q       <= '0;
      cnt_q       <= '0;
      opcode_q    <= '0;
      vaddr_q     <= '0;
      page_q      <= '0;
      frame_q     <= '0;
      ftf_q       <= '0;
      hold_q      <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      ptr_q       <= ptr_d;
      row_q       <= row_d;
      cnt_q       <= cnt_d;
      opcode_q    <= opcode_d;
      vaddr_q     <= vaddr_d;
      page_q      <= page_d;
      frame_q     <= frame_d;
      ftf_q       <= ftf_d;
      hold_q      <= hold_d;
      out_q       <= out_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign status_o      = out_q.status;
  assign frame_id_o    = out_q.frame_id;
  assign phys_addr_o   = out_q.phys_addr;
  assign free_frames_o = out_q.free_frames;

endmodule

[hw/rtl/ptfa_ram.sv]
module ptfa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[hw/rtl/ptfa_find_free.sv]
module ptfa_find_free #(
  parameter int unsigned FRAME_COUNT = ptfa_pkg::FRAME_COUNT_DEF,
  parameter int unsigned ROW_AW      = 1
) (
  input  logic [ROW_AW-1:0]          row_i,
  input  logic [ptfa_pkg::ROW_W-1:0] busy_i,
  output ptfa_pkg::pick_t            pick_o
);

  // lowest clear bit whose frame number lies below the frame count
  always_comb begin
    pick_o = '0;
    for (int b = ptfa_pkg::ROW_W - 1; b >= 0; b--) begin
      if (!busy_i[b] &&
          (32'({row_i, ptfa_pkg::BIT_W'(b)}) < FRAME_COUNT)) begin
        pick_o.found = 1'b1;
        pick_o.idx   = ptfa_pkg::BIT_W'(b);
      end
    end
  end

endmodule

[test/tb.sv]
module tb;

  localparam int NUM_FRAMES   = 64;
  localparam int NUM_PAGES    = 256;
  localparam int PAGE_SHIFT   = 8;
  localparam int RANDOM_WORDS = 950;
  localparam int DRAIN_CYCLES = 600;
  localparam int STUCK_LIMIT  = 5000;
  localparam int HOLD_CYCLES  = 150;

  // opcodes with no operation behind them
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  typedef enum logic [1:0] {PH_OUT_SLOW, PH_IN_SLOW, PH_NO_IDLE} idle_phase_t;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [15:0] vaddr;
    logic [7:0]  page;
    logic [5:0]  frame;
  } page_req_t;

  logic        clk      = 1'b0;
  logic        rst_n    = 1'b0;
  logic        in_valid = 1'b0;
  logic        out_stall = 1'b0;
  page_req_t   cur_req  = '0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic [1:0]  status_o;
  logic [5:0]  frame_id_o;
  logic [13:0] phys_addr_o;
  logic [6:0]  free_frames_o;

  // shadow of the busy bitmap and the page table
  logic [NUM_FRAMES-1:0]      frame_taken = '0;
  logic [ptfa_pkg::ENT_W-1:0] page_map [NUM_PAGES] = '{default: '0};

  page_req_t       req_queue [$];
  logic [7:0]      mapped_pages [$];
  ptfa_pkg::res_t  expected_results [$];

  // cumulative opcode weights per traffic mode, last slot is a spare opcode
  int          op_cut [4][7] = '{'{75, 78, 88, 88, 96, 98, 100},
                                 '{15, 60, 80, 83, 95, 98, 100},
                                 '{15, 20, 45, 46, 94, 98, 100},
                                 '{30, 50, 68, 70, 92, 97, 100}};
  logic [2:0]  slot_op [7] = '{ptfa_pkg::OP_ALLOC, ptfa_pkg::OP_FREE_FRAME,
                               ptfa_pkg::OP_MAP, ptfa_pkg::OP_FREE_TABLE,
                               ptfa_pkg::OP_TRANSLATE, ptfa_pkg::OP_COUNT,
                               OP_SPARE_6};

  idle_phase_t     idle_phase = PH_OUT_SLOW;
  int              send_idle_pct;
  int              recv_idle_pct;
  int              total_words  = 0;
  int              sent_words   = 0;
  int              inputs_taken = 0;
  int              results_seen = 0;
  int              mismatches   = 0;
  int              stuck_cycles = 0;
  int              hold_left    = 0;
  logic            hold_done    = 1'b0;
  logic            in_took;
  logic            out_took;
  page_req_t       next_req;
  ptfa_pkg::res_t  seen;
  ptfa_pkg::res_t  want;

  assign send_idle_pct = (idle_phase == PH_OUT_SLOW) ? 9 :
                         (idle_phase == PH_IN_SLOW) ? 70 : 0;
  assign recv_idle_pct = (idle_phase == PH_OUT_SLOW) ? 70 :
                         (idle_phase == PH_IN_SLOW) ? 9 : 0;

  page_table_frame_allocator u_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall_o),
    .opcode_i      (cur_req.opcode),
    .vaddr_i       (cur_req.vaddr),
    .page_i        (cur_req.page),
    .frame_i       (cur_req.frame),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall),
    .status_o      (status_o),
    .frame_id_o    (frame_id_o),
    .phys_addr_o   (phys_addr_o),
    .free_frames_o (free_frames_o)
  );

  // one table operation on the shadow state, returns the result word
  function automatic ptfa_pkg::res_t apply_table_op(page_req_t req);
    ptfa_pkg::res_t r;
    logic [9:0]     ent;
    int             n;
    r = '0;
    case (req.opcode)
      ptfa_pkg::OP_ALLOC: begin
        r.status = ptfa_pkg::ST_NO_FRAME;
        for (int i = 0; i < NUM_FRAMES; i++) begin
          if (!frame_taken[i] && r.status == ptfa_pkg::ST_NO_FRAME) begin
            frame_taken[i] = 1'b1;
            r.frame_id = 6'(i);
            r.status = ptfa_pkg::ST_OK;
          end
        end
      end
      ptfa_pkg::OP_FREE_FRAME: frame_taken[req.frame] = 1'b0;
      ptfa_pkg::OP_MAP: page_map[req.page] = {ptfa_pkg::ENT_MAP_FLAGS, req.frame};
      ptfa_pkg::OP_FREE_TABLE: begin
        for (int i = 0; i < NUM_PAGES; i++) begin
          ent = page_map[i];
          if (ent[ptfa_pkg::ENT_PRESENT]) begin
            frame_taken[ent[ptfa_pkg::ENT_FRAME_W-1:0]] = 1'b0;
            page_map[i] = '0;
          end
        end
      end
      ptfa_pkg::OP_TRANSLATE: begin
        ent = page_map[req.vaddr[15:PAGE_SHIFT]];
        if (!ent[ptfa_pkg::ENT_PRESENT]) r.status = ptfa_pkg::ST_NOT_PRESENT;
        else r.phys_addr = {ent[ptfa_pkg::ENT_FRAME_W-1:0], req.vaddr[PAGE_SHIFT-1:0]};
      end
      default: ;
    endcase
    n = 0;
    for (int i = 0; i < NUM_FRAMES; i++) begin
      if (!frame_taken[i]) n++;
    end
    r.free_frames = 7'(n);
    return r;
  endfunction

  // queue a word, keep track of mapped pages so translates mostly hit
  function automatic void push_req(logic [2:0] op, logic [15:0] va, logic [7:0] pg,
                                   logic [5:0] fr);
    req_queue.push_back({op, va, pg, fr});
    if (op == ptfa_pkg::OP_MAP) mapped_pages.push_back(pg);
    else if (op == ptfa_pkg::OP_FREE_TABLE) mapped_pages.delete();
  endfunction

  task automatic check_field(string name, int unsigned exp_val, int unsigned act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s expected %0d got %0d", $time, name, exp_val, act_val);
      mismatches++;
    end
  endtask

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // stimulus, reset and end of run
  initial begin
    int         mode;
    int         chunk_left;
    int         roll;
    int         slot;
    logic [2:0] op;
    logic [15:0] va;
    logic [7:0] pg;
    logic [5:0] fr;

    // directed words
    push_req(ptfa_pkg::OP_COUNT, 16'h0000, 8'h00, 6'd0);
    push_req(ptfa_pkg::OP_TRANSLATE, 16'h0000, 8'h00, 6'd0);
    push_req(ptfa_pkg::OP_ALLOC, 16'h0000, 8'h00, 6'd0);
    push_req(ptfa_pkg::OP_ALLOC, 16'hFFFF, 8'hFF, 6'd63);
    push_req(ptfa_pkg::OP_MAP, 16'h0000, 8'h00, 6'd0);
    push_req(ptfa_pkg::OP_MAP, 16'hFFFF, 8'hFF, 6'd63);
    push_req(ptfa_pkg::OP_TRANSLATE, 16'h00FF, 8'h00, 6'd0);
    push_req(ptfa_pkg::OP_TRANSLATE, 16'hFFFF, 8'h00, 6'd0);
    push_req(ptfa_pkg::OP_TRANSLATE, 16'h8000, 8'h00, 6'd0);
    // remap of a present page overwrites it
    push_req(ptfa_pkg::OP_MAP, 16'h0000, 8'h00, 6'd42);
    push_req(ptfa_pkg::OP_TRANSLATE, 16'h0001, 8'h00, 6'd0);
    push_req(ptfa_pkg::OP_FREE_FRAME, 16'h0000, 8'h00, 6'd1);
    // freeing frames that are already free
    push_req(ptfa_pkg::OP_FREE_FRAME, 16'h0000, 8'h00, 6'd1);
    push_req(ptfa_pkg::OP_FREE_FRAME, 16'h0000, 8'h00, 6'd63);
    push_req(ptfa_pkg::OP_ALLOC, 16'h0000, 8'h00, 6'd0);
    push_req(ptfa_pkg::OP_FREE_TABLE, 16'h0000, 8'h00, 6'd0);
    push_req(ptfa_pkg::OP_TRANSLATE, 16'hFF00, 8'h00, 6'd0);
    push_req(OP_SPARE_6, 16'hFFFF, 8'hFF, 6'd63);
    push_req(OP_SPARE_7, 16'hFFFF, 8'hFF, 6'd63);
    // table release that frees a busy frame
    push_req(ptfa_pkg::OP_MAP, 16'h0000, 8'h07, 6'd0);
    push_req(ptfa_pkg::OP_FREE_TABLE, 16'hFFFF, 8'hFF, 6'd63);
    push_req(ptfa_pkg::OP_COUNT, 16'hFFFF, 8'hFF, 6'd63);
    push_req(ptfa_pkg::OP_ALLOC, 16'h0000, 8'h00, 6'd0);

    // random words in chunks, the first chunk drains the frame pool
    chunk_left = 0;
    for (int made = 0; made < RANDOM_WORDS; made++) begin
      if (chunk_left == 0) begin
        mode = (made == 0) ? 0 : $urandom_range(0, 3);
        chunk_left = (made == 0) ? 100 : 40;
      end
      chunk_left--;
      roll = $urandom_range(0, 99);
      slot = 0;
      while (roll >= op_cut[mode][slot]) slot++;
      op = slot_op[slot];
      if (op == OP_SPARE_6 && $urandom_range(0, 1) == 1) op = OP_SPARE_7;
      va = 16'($urandom);
      if (op == ptfa_pkg::OP_TRANSLATE && mapped_pages.size() > 0 &&
          $urandom_range(0, 99) < 75)
        va = {mapped_pages[$urandom_range(0, mapped_pages.size() - 1)], 8'($urandom)};
      pg = 8'($urandom);
      fr = ($urandom_range(0, 1) == 1) ? 6'($urandom_range(0, 15)) : 6'($urandom);
      push_req(op, va, pg, fr);
    end
    total_words = req_queue.size();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (inputs_taken != total_words || results_seen < total_words) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    if (mismatches == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end

  // driver: next word from the queue, or an idle cycle
  always @(posedge clk) begin
    if (rst_n && (!in_valid || in_stall_o === 1'b0)) begin
      if (req_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        next_req = req_queue.pop_front();
        cur_req <= next_req;
        in_valid <= 1'b1;
        sent_words <= sent_words + 1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    if (sent_words >= (2 * total_words) / 3) idle_phase <= PH_NO_IDLE;
    else if (sent_words >= total_words / 3) idle_phase <= PH_IN_SLOW;
  end

  // receiver stall, with one long hold-off when the steady phase starts
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (idle_phase == PH_NO_IDLE && !hold_done) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES - 1;
      hold_done <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // monitor: check result words, predict accepted input words, watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      out_took = (out_valid_o === 1'b1) && !out_stall;
      in_took = in_valid && (in_stall_o === 1'b0);
      if (out_took) begin
        seen = {status_o, frame_id_o, phys_addr_o, free_frames_o};
        if (expected_results.size() == 0) begin
          $display("%0t: result word with nothing outstanding, expected none got %0h",
                   $time, seen);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("status", want.status, seen.status);
          check_field("frame_id", want.frame_id, seen.frame_id);
          check_field("phys_addr", want.phys_addr, seen.phys_addr);
          check_field("free_frames", want.free_frames, seen.free_frames);
        end
        results_seen <= results_seen + 1;
      end
      if (in_took) begin
        expected_results.push_back(apply_table_op(cur_req));
        inputs_taken <= inputs_taken + 1;
      end
      if (in_took || out_took) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles = stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT) begin
          $display("tb failed");
          $finish;
        end
      end
    end
  end

endmodule

[files.f]
hw/rtl/ptfa_pkg.sv
hw/rtl/ptfa_ram.sv
hw/rtl/ptfa_find_free.sv
hw/rtl/page_table_frame_allocator.sv
test/tb.sv
